### rtl/imu_burst_read_sequencer_assert.svh
// assertion macros for the burst read sequencer rtl
// no dependencies; included inside module bodies after the logic
`ifndef IMU_BURST_READ_SEQUENCER_ASSERT_SVH
`define IMU_BURST_READ_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IBRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define IBRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ibrs_pkg.sv
// shared types and constants of the burst read sequencer
// no dependencies
`timescale 1ns / 1ps

package ibrs_pkg;

  localparam int unsigned BURST_BYTES = 14;
  localparam int unsigned NUM_CH      = 7;
  localparam int unsigned SUM_OUT_W   = 32;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned KIND_W      = 2;

  localparam logic [7:0] DEV_ADDR_RESET = 8'd208;
  localparam logic [7:0] DATA_REG       = 8'h3B;
  localparam logic [7:0] ADDR_WR_MASK   = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT    = 8'h01;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVENT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

  // bus actions
  localparam logic [ACT_W-1:0] ACT_TX     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RSTART = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RECV   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ACK    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STOP   = 3'd4;

  // first byte of each channel word, in output order, and which get negated
  localparam int unsigned CH_BYTE_IDX [NUM_CH] = '{2, 0, 4, 6, 10, 8, 12};
  localparam bit          CH_NEGATE   [NUM_CH] = '{1'b0, 1'b0, 1'b1, 1'b0,
                                                   1'b0, 1'b0, 1'b1};

  typedef logic [BURST_BYTES-1:0][7:0]       byte_buf_t;
  typedef logic [NUM_CH-1:0][SUM_OUT_W-1:0]  sum_vec_t;

  typedef struct packed {
    logic restart;
    logic event_go;
  } seq_req_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [7:0]       tx_byte;
    logic             ack_level;
    logic             stop;
  } seq_rsp_t;

  typedef struct packed {
    logic load;
    logic clear;
  } acc_ctl_t;

endpackage

### rtl/ibrs_seq.sv
// bus sequencer state machine and receive byte buffer
// depends on ibrs_pkg
`timescale 1ns / 1ps

module ibrs_seq (
  input  logic              clk,
  input  logic              rst,
  input  ibrs_pkg::seq_req_t req,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        device_address,
  output ibrs_pkg::seq_rsp_t rsp,
  output ibrs_pkg::byte_buf_t rx_buf
);
  import ibrs_pkg::*;

  localparam logic [2:0] ST_ADDR_W  = 3'd0;
  localparam logic [2:0] ST_REG     = 3'd1;
  localparam logic [2:0] ST_RSTART  = 3'd2;
  localparam logic [2:0] ST_ADDR_R  = 3'd3;
  localparam logic [2:0] ST_RECV_EN = 3'd4;
  localparam logic [2:0] ST_RX      = 3'd5;
  localparam logic [2:0] ST_REARM   = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [3:0] byte_pos;
  logic [3:0] byte_pos_next;
  logic       buf_wr;
  logic       pos_in_range;
  byte_buf_t  bytes;

  assign pos_in_range = byte_pos < 4'(BURST_BYTES);

  always_comb begin
    rsp           = '0;
    state_next    = state;
    byte_pos_next = byte_pos;
    buf_wr        = 1'b0;
    case (state)
      ST_ADDR_W: begin
        rsp.action  = ACT_TX;
        rsp.tx_byte = device_address & ADDR_WR_MASK;
        state_next  = ST_REG;
      end
      ST_REG: begin
        rsp.action  = ACT_TX;
        rsp.tx_byte = DATA_REG;
        state_next  = ST_RSTART;
      end
      ST_RSTART: begin
        rsp.action = ACT_RSTART;
        state_next = ST_ADDR_R;
      end
      ST_ADDR_R: begin
        rsp.action  = ACT_TX;
        rsp.tx_byte = device_address | ADDR_RD_BIT;
        state_next  = ST_RECV_EN;
      end
      ST_RECV_EN: begin
        rsp.action    = ACT_RECV;
        byte_pos_next = '0;
        state_next    = ST_RX;
      end
      ST_RX: begin
        rsp.action = ACT_ACK;
        buf_wr     = pos_in_range;
        if (pos_in_range) begin
          byte_pos_next = byte_pos + 4'd1;
        end
        // nack on the last byte or on an overrun
        if ((byte_pos_next < 4'(BURST_BYTES)) && (byte_pos_next != 4'd0)) begin
          rsp.ack_level = 1'b0;
          state_next    = ST_REARM;
        end else begin
          rsp.ack_level = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_REARM: begin
        rsp.action = ACT_RECV;
        state_next = ST_RX;
      end
      ST_DONE: begin
        rsp.action = ACT_STOP;
        rsp.stop   = 1'b1;
      end
      default: begin
        rsp.action = ACT_STOP;
        rsp.stop   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ADDR_W;
      byte_pos <= '0;
    end else if (req.restart) begin
      state <= ST_ADDR_W;
    end else if (req.event_go) begin
      state    <= state_next;
      byte_pos <= byte_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.event_go && buf_wr) begin
      bytes[byte_pos] <= rx_byte;
    end
  end

  assign rx_buf = bytes;

endmodule

### rtl/ibrs_accum.sv
// channel word assembly, axis remap and running sums with sample count
// depends on ibrs_pkg
`timescale 1ns / 1ps

module ibrs_accum #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ibrs_pkg::acc_ctl_t          ctl,
  input  ibrs_pkg::byte_buf_t         rx_buf,
  output ibrs_pkg::sum_vec_t          sums_next_out,
  output logic [ibrs_pkg::COUNT_W-1:0] count_next
);
  import ibrs_pkg::*;

  logic [NUM_CH-1:0][SUM_WIDTH-1:0] sums;
  logic [NUM_CH-1:0][SUM_WIDTH-1:0] sums_next;
  logic [COUNT_W-1:0]               count;
  logic                             first_sample;

  assign first_sample = count == '0;
  assign count_next   = count + COUNT_W'(1);

  for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
    logic [15:0]          raw;
    logic [15:0]          word;
    logic [SUM_WIDTH-1:0] word_ext;

    assign raw      = {rx_buf[CH_BYTE_IDX[k]], rx_buf[CH_BYTE_IDX[k] + 1]};
    // negation wraps at 16 bits, so -32768 stays -32768
    assign word     = CH_NEGATE[k] ? 16'(16'd0 - raw) : raw;
    assign word_ext = {{(SUM_WIDTH - 16){word[15]}}, word};

    assign sums_next[k]     = first_sample ? word_ext : sums[k] + word_ext;
    assign sums_next_out[k] = sums_next[k][SUM_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sums <= sums_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.load) begin
      count <= count_next;
    end
  end

endmodule

### rtl/imu_burst_read_sequencer.sv
// Burst read sequencer for an i2c inertial sensor: each bus-event transaction
// yields one result transaction (the next bus action) and the stop after the
// 14-byte read carries the updated channel sums and sample count. Restart and
// clear transactions only change state and give no result. The block takes one
// transaction per clock: an input register feeds the sequencer and accumulator
// and a result register holds the outgoing transaction, so a result passes
// through both after its input is accepted. Input is held off only while a
// bus-event waits in the input register behind a result not yet taken; the
// seven sum adders are the only wide logic, one adder deep per channel.
// depends on ibrs_pkg, ibrs_seq, ibrs_accum and the assertion header
`timescale 1ns / 1ps

module imu_burst_read_sequencer #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: sensor bus address byte
  input  logic                        cfg_wr_en,
  input  logic [7:0]                  cfg_wr_data,
  // input transactions
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ibrs_pkg::KIND_W-1:0] kind,
  input  logic [7:0]                  rx_byte,
  // result transactions
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ibrs_pkg::ACT_W-1:0]  action,
  output logic [7:0]                  tx_byte,
  output logic                        ack_level,
  output logic signed [31:0]          sum_accel_x,
  output logic signed [31:0]          sum_accel_y,
  output logic signed [31:0]          sum_accel_z,
  output logic signed [31:0]          sum_temperature,
  output logic signed [31:0]          sum_gyro_x,
  output logic signed [31:0]          sum_gyro_y,
  output logic signed [31:0]          sum_gyro_z,
  output logic [ibrs_pkg::COUNT_W-1:0] samples_summed,
  output logic                        sample_done
);
  import ibrs_pkg::*;

  // device address register
  logic [7:0] dev_addr;

  // input register
  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [7:0]        s1_rx;
  logic              s1_is_event;
  logic              s1_fire;
  logic              ev_fire;

  // datapath between sequencer and accumulator
  seq_req_t           seq_req;
  seq_rsp_t           seq_rsp;
  acc_ctl_t           acc_ctl;
  byte_buf_t          rx_buf;
  sum_vec_t           acc_sums;
  logic [COUNT_W-1:0] acc_count;

  // result register
  sum_vec_t out_sums;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= DEV_ADDR_RESET;
    end else if (cfg_wr_en) begin
      dev_addr <= cfg_wr_data;
    end
  end

  // a bus event may only leave the input register when the result slot frees
  assign s1_is_event = s1_kind == KIND_EVENT;
  assign s1_fire     = s1_valid && (!s1_is_event || !out_valid || out_ready);
  assign ev_fire     = s1_fire && s1_is_event;
  assign in_ready    = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind <= kind;
      s1_rx   <= rx_byte;
    end
  end

  assign seq_req.restart  = s1_fire && (s1_kind == KIND_RESTART);
  assign seq_req.event_go = ev_fire;

  ibrs_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .req            (seq_req),
    .rx_byte        (s1_rx),
    .device_address (dev_addr),
    .rsp            (seq_rsp),
    .rx_buf         (rx_buf)
  );

  // stop accumulates the buffer; kind 3 falls through as a no-op
  assign acc_ctl.load  = ev_fire && seq_rsp.stop;
  assign acc_ctl.clear = s1_fire && (s1_kind == KIND_CLEAR);

  ibrs_accum #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .ctl           (acc_ctl),
    .rx_buf        (rx_buf),
    .sums_next_out (acc_sums),
    .count_next    (acc_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ev_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sums and count read as zero except on the completing stop
  always_ff @(posedge clk) begin
    if (ev_fire) begin
      action         <= seq_rsp.action;
      tx_byte        <= seq_rsp.tx_byte;
      ack_level      <= seq_rsp.ack_level;
      sample_done    <= seq_rsp.stop;
      out_sums       <= seq_rsp.stop ? acc_sums : '0;
      samples_summed <= seq_rsp.stop ? acc_count : '0;
    end
  end

  // output order follows the vehicle frame: x/y swapped, z negated upstream
  assign sum_accel_x     = $signed(out_sums[0]);
  assign sum_accel_y     = $signed(out_sums[1]);
  assign sum_accel_z     = $signed(out_sums[2]);
  assign sum_temperature = $signed(out_sums[3]);
  assign sum_gyro_x      = $signed(out_sums[4]);
  assign sum_gyro_y      = $signed(out_sums[5]);
  assign sum_gyro_z      = $signed(out_sums[6]);

  `include "imu_burst_read_sequencer_assert.svh"

  `IBRS_ASSERT_NOW(a_done_is_stop, clk, rst, out_valid && sample_done, action == ACT_STOP, "sample_done without stop")
  `IBRS_ASSERT_NOW(a_nack_on_ack, clk, rst, out_valid && ack_level, action == ACT_ACK, "ack_level set outside ack action")
  `IBRS_ASSERT_NOW(a_tx_only, clk, rst, out_valid && (tx_byte != 8'd0), action == ACT_TX, "tx_byte set outside transmit")
  `IBRS_ASSERT_NOW(a_stall_cause, clk, rst, !in_ready, s1_valid && s1_is_event && out_valid && !out_ready, "input stalled without a blocked event")
  `IBRS_ASSERT_NEXT(a_stop_result, clk, rst, ev_fire && seq_rsp.stop, out_valid && sample_done, "stop did not produce a completed sample")

endmodule

### tb/imu_burst_read_sequencer_checker.sv
// scoreboard for the burst read sequencer: mirrors the bus sequence, byte
// capture and channel accumulators, and checks every result transaction in order
// depends on ibrs_pkg
`timescale 1ns / 1ps

module imu_burst_read_sequencer_checker
  import ibrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [KIND_W-1:0]    kind,
  input  logic [7:0]           rx_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [ACT_W-1:0]     action,
  input  logic [7:0]           tx_byte,
  input  logic                 ack_level,
  input  logic signed [31:0]   sum_accel_x,
  input  logic signed [31:0]   sum_accel_y,
  input  logic signed [31:0]   sum_accel_z,
  input  logic signed [31:0]   sum_temperature,
  input  logic signed [31:0]   sum_gyro_x,
  input  logic signed [31:0]   sum_gyro_y,
  input  logic signed [31:0]   sum_gyro_z,
  input  logic [COUNT_W-1:0]   samples_summed,
  input  logic                 sample_done,
  output int                   mismatches,
  output int                   pending
);

  typedef enum logic [2:0] {
    PH_ADDR_WR, PH_REG, PH_RSTART, PH_ADDR_RD,
    PH_RECV_FIRST, PH_ACK, PH_RECV_NEXT, PH_STOP
  } bus_phase_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [7:0]         tx_byte;
    logic               ack_level;
    sum_vec_t           sums;
    logic [COUNT_W-1:0] count;
    logic               done;
  } bus_result_t;

  bus_phase_t         phase;
  logic [3:0]         byte_pos;
  logic [7:0]         rx_bytes [BURST_BYTES];
  logic [31:0]        acc [NUM_CH];
  logic [COUNT_W-1:0] n_samples;
  logic [7:0]         dev_addr;

  bus_result_t pending_results [$];
  bus_result_t want;
  sum_vec_t    got_sums;

  string ch_name [NUM_CH] = '{"sum_accel_x", "sum_accel_y", "sum_accel_z",
                              "sum_temperature", "sum_gyro_x", "sum_gyro_y",
                              "sum_gyro_z"};

  assign got_sums = {sum_gyro_z, sum_gyro_y, sum_gyro_x, sum_temperature,
                     sum_accel_z, sum_accel_y, sum_accel_x};

  initial mismatches = 0;

  task automatic report(input string msg);
    if (mismatches < 20)
      $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report($sformatf("%s got %0h, expected %0h", name, got, exp_val));
  endtask

  // big-endian word from the captured bytes, optionally negated at 16 bits
  function automatic logic [31:0] channel_word(input int unsigned first,
                                               input bit negate);
    logic [15:0] w;
    w = {rx_bytes[first], rx_bytes[first + 1]};
    if (negate)
      w = -w;
    return {{16{w[15]}}, w};
  endfunction

  // stop: fold the captured sample into the sums, axes swapped, z negated
  function automatic void fold_sample(inout bus_result_t r);
    logic [31:0] word [NUM_CH];
    word[0] = channel_word(2, 1'b0);
    word[1] = channel_word(0, 1'b0);
    word[2] = channel_word(4, 1'b1);
    word[3] = channel_word(6, 1'b0);
    word[4] = channel_word(10, 1'b0);
    word[5] = channel_word(8, 1'b0);
    word[6] = channel_word(12, 1'b1);
    for (int k = 0; k < NUM_CH; k++) begin
      acc[k] = (n_samples == '0) ? word[k] : acc[k] + word[k];
      r.sums[k] = acc[k];
    end
    n_samples = n_samples + 1'b1;
    r.count = n_samples;
    r.done = 1'b1;
  endfunction

  // one bus event: next action of the sequencer
  function automatic void advance_sequence(input logic [7:0] rx);
    bus_result_t r;
    r = '0;
    case (phase)
      PH_ADDR_WR: begin
        r.action = ACT_TX;
        r.tx_byte = dev_addr & ADDR_WR_MASK;
        phase = PH_REG;
      end
      PH_REG: begin
        r.action = ACT_TX;
        r.tx_byte = DATA_REG;
        phase = PH_RSTART;
      end
      PH_RSTART: begin
        r.action = ACT_RSTART;
        phase = PH_ADDR_RD;
      end
      PH_ADDR_RD: begin
        r.action = ACT_TX;
        r.tx_byte = dev_addr | ADDR_RD_BIT;
        phase = PH_RECV_FIRST;
      end
      PH_RECV_FIRST: begin
        r.action = ACT_RECV;
        byte_pos = '0;
        phase = PH_ACK;
      end
      PH_ACK: begin
        if (byte_pos < BURST_BYTES) begin
          rx_bytes[byte_pos] = rx;
          byte_pos = byte_pos + 4'd1;
        end
        r.action = ACT_ACK;
        if (byte_pos < BURST_BYTES && byte_pos != '0) begin
          phase = PH_RECV_NEXT;
        end else begin
          r.ack_level = 1'b1;
          phase = PH_STOP;
        end
      end
      PH_RECV_NEXT: begin
        r.action = ACT_RECV;
        phase = PH_ACK;
      end
      default: begin
        r.action = ACT_STOP;
        fold_sample(r);
      end
    endcase
    pending_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase = PH_ADDR_WR;
      byte_pos = '0;
      n_samples = '0;
      dev_addr = DEV_ADDR_RESET;
      foreach (acc[k]) acc[k] = '0;
      foreach (rx_bytes[k]) rx_bytes[k] = '0;
      pending_results.delete();
    end else begin
      if (cfg_wr_en)
        dev_addr = cfg_wr_data;
      if (in_valid && in_ready) begin
        case (kind)
          KIND_RESTART: phase = PH_ADDR_WR;
          KIND_EVENT:   advance_sequence(rx_byte);
          KIND_CLEAR:   n_samples = '0;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result with nothing expected, action %0d", action));
        end else begin
          want = pending_results.pop_front();
          check_field("action", action, want.action);
          check_field("tx_byte", tx_byte, want.tx_byte);
          check_field("ack_level", ack_level, want.ack_level);
          for (int k = 0; k < NUM_CH; k++)
            check_field(ch_name[k], got_sums[k], want.sums[k]);
          check_field("samples_summed", samples_summed, want.count);
          check_field("sample_done", sample_done, want.done);
        end
      end
    end
    pending <= pending_results.size();
  end

endmodule

### tb/tb.sv
// top of the burst read sequencer testbench: clock, reset, stimulus and verdict
// depends on ibrs_pkg, imu_burst_read_sequencer and imu_burst_read_sequencer_checker
`timescale 1ns / 1ps

module tb;
  import ibrs_pkg::*;

  // kind with no meaning to the block, must be swallowed silently
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

  localparam int GAP_PCT      = 36;     // idle / stall odds per cycle, percent
  localparam int STALL_LIMIT  = 2000;   // cycles without any transaction
  localparam int DRAIN_CYCLES = 6;      // extra wait once no result is pending
  localparam int RANDOM_ITEMS = 600;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [7:0]         cfg_wr_data = 8'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KIND_W-1:0]  kind = KIND_RESTART;
  logic [7:0]         rx_byte = 8'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ACT_W-1:0]   action;
  logic [7:0]         tx_byte;
  logic               ack_level;
  logic signed [31:0] sum_accel_x;
  logic signed [31:0] sum_accel_y;
  logic signed [31:0] sum_accel_z;
  logic signed [31:0] sum_temperature;
  logic signed [31:0] sum_gyro_x;
  logic signed [31:0] sum_gyro_y;
  logic signed [31:0] sum_gyro_z;
  logic [COUNT_W-1:0] samples_summed;
  logic               sample_done;

  bit   gaps_on = 1'b0;
  int   fail_count;
  int   results_pending;
  int   quiet_cycles = 0;
  int   items_sent = 0;
  logic [7:0] pattern [BURST_BYTES];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  imu_burst_read_sequencer dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .action          (action),
    .tx_byte         (tx_byte),
    .ack_level       (ack_level),
    .sum_accel_x     (sum_accel_x),
    .sum_accel_y     (sum_accel_y),
    .sum_accel_z     (sum_accel_z),
    .sum_temperature (sum_temperature),
    .sum_gyro_x      (sum_gyro_x),
    .sum_gyro_y      (sum_gyro_y),
    .sum_gyro_z      (sum_gyro_z),
    .samples_summed  (samples_summed),
    .sample_done     (sample_done)
  );

  imu_burst_read_sequencer_checker bus_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .action          (action),
    .tx_byte         (tx_byte),
    .ack_level       (ack_level),
    .sum_accel_x     (sum_accel_x),
    .sum_accel_y     (sum_accel_y),
    .sum_accel_z     (sum_accel_z),
    .sum_temperature (sum_temperature),
    .sum_gyro_x      (sum_gyro_x),
    .sum_gyro_y      (sum_gyro_y),
    .sum_gyro_z      (sum_gyro_z),
    .samples_summed  (samples_summed),
    .sample_done     (sample_done),
    .mismatches      (fail_count),
    .pending         (results_pending)
  );

  // result side back-pressure, follows the same idle switch as the sender
  always @(posedge clk)
    out_ready <= gaps_on ? ($urandom_range(99) >= GAP_PCT) : 1'b1;

  // watchdog: a long run with no transaction on either side means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[imu_burst_read_sequencer] ERROR");
      $finish;
    end
  end

  // drop valid for one cycle; valid only ever falls here
  task automatic hold_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // offer one input transaction and wait for it to be taken; valid stays
  // high afterward so back-to-back transactions need not lower it
  task automatic push_item(input logic [KIND_W-1:0] k, input logic [7:0] b);
    if (gaps_on)
      while ($urandom_range(99) < GAP_PCT)
        hold_input();
    in_valid <= 1'b1;
    kind     <= k;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    if (k != KIND_IGNORED)
      items_sent++;
  endtask

  // sender pause until every result is out, plus the pipeline tail, since
  // restart and clear transactions leave nothing to wait on
  task automatic wait_drained();
    hold_input();
    while (results_pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_device_address(input logic [7:0] a);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // sensor bytes lean toward the sign and range edges
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // full well-formed read: restart, address/register/restart/address, first
  // receive, then 14 ack events carrying data with receives between them,
  // and one or more stops (extra stops re-accumulate the same bytes)
  task automatic burst_read(input logic [7:0] data [BURST_BYTES], input int stops);
    push_item(KIND_RESTART, 8'($urandom_range(255)));
    repeat (5) push_item(KIND_EVENT, 8'($urandom_range(255)));
    for (int i = 0; i < BURST_BYTES; i++) begin
      push_item(KIND_EVENT, data[i]);
      if (i != BURST_BYTES - 1)
        push_item(KIND_EVENT, 8'($urandom_range(255)));
    end
    repeat (stops) push_item(KIND_EVENT, 8'($urandom_range(255)));
  endtask

  // mostly complete reads with random bytes; some are cut short by a restart
  // and sprinkled with clear and ignored transactions
  task automatic random_read();
    logic [7:0] bytes [BURST_BYTES];
    int cut;
    foreach (bytes[i]) bytes[i] = pick_byte();
    if ($urandom_range(4) == 0) begin
      cut = $urandom_range(34);
      push_item(KIND_RESTART, 8'($urandom_range(255)));
      repeat (cut) begin
        case ($urandom_range(5))
          0: push_item(KIND_CLEAR, 8'($urandom_range(255)));
          1: push_item(KIND_IGNORED, 8'($urandom_range(255)));
          2: push_item(KIND_RESTART, 8'($urandom_range(255)));
          default: push_item(KIND_EVENT, pick_byte());
        endcase
      end
    end else begin
      burst_read(bytes, $urandom_range(1, 3));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ignored kind, clear, header with the reset address
    push_item(KIND_IGNORED, 8'hFF);
    push_item(KIND_CLEAR, 8'h00);
    repeat (4) push_item(KIND_EVENT, 8'h00);
    // sender pause in the middle of a sequence
    wait_drained();
    push_item(KIND_EVENT, 8'hFF);

    // address extremes, header only
    push_item(KIND_RESTART, 8'hAA);
    set_device_address(8'hFF);
    repeat (4) push_item(KIND_EVENT, 8'h55);
    push_item(KIND_RESTART, 8'h00);
    set_device_address(8'h00);
    repeat (4) push_item(KIND_EVENT, 8'hFF);

    // word extremes: min accel z negates to itself, temperature all ones
    pattern = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF,
                8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01};
    burst_read(pattern, 1);
    // min gyro z, zero accel z, and repeated stops after completion
    pattern = '{8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h80, 8'h00};
    burst_read(pattern, 3);

    // random phase, with a stretch of six reads with no idling at all
    set_device_address(DEV_ADDR_RESET);
    items_sent = 0;
    for (int r = 0; items_sent < RANDOM_ITEMS; r++) begin
      gaps_on = !(r >= 6 && r < 12);
      if ($urandom_range(7) == 0)
        set_device_address(8'($urandom_range(255)));
      if ($urandom_range(5) == 0)
        push_item(KIND_CLEAR, 8'($urandom_range(255)));
      random_read();
    end

    wait_drained();
    if (fail_count == 0)
      $display("[imu_burst_read_sequencer] OK");
    else
      $display("[imu_burst_read_sequencer] ERROR");
    $finish;
  end

endmodule
